/* rtl/bpit_pkg.sv */
// Shared constants for the barycentric point-in-triangle block.
package bpit_pkg;
    // Width of the reported barycentric weights (signed, saturated).
    localparam int OUT_BITS = 20;
endpackage

/* rtl/bpit_in_if.sv */
// Query channel: one point and one triangle per beat.
interface bpit_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_a_z;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_b_z;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic signed [COORD_BITS-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

/* rtl/bpit_out_if.sv */
// Result channel: inside flag, degenerate flag and the two weights per beat.
interface bpit_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 inside_res;
    logic                                 degenerate;
    logic signed [bpit_pkg::OUT_BITS-1:0] bary_u;
    logic signed [bpit_pkg::OUT_BITS-1:0] bary_v;

    modport source (
        output valid, inside_res, degenerate, bary_u, bary_v,
        input  ready
    );
    modport sink (
        input  valid, inside_res, degenerate, bary_u, bary_v,
        output ready
    );
endinterface

/* rtl/barycentric_point_in_triangle.sv */
// Barycentric point-in-triangle test: fully pipelined top level.
// Throughput: one query beat per cycle while the output is not stalled.
// The restoring divider, one quotient bit per stage, sets the depth.
// Reset: synchronous active-low i_rst_n clears all valid bits and the tolerance register.
// A stalled output holds the whole pipe; nothing is lost or repeated.
// Tolerance is read live by the pipe, so write it only while the block is idle.
module barycentric_point_in_triangle #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [FRAC_BITS:0]   i_cfg_wdata,
    bpit_in_if.sink              i_pt,
    bpit_out_if.source           o_res
);
    localparam int OB = bpit_pkg::OUT_BITS;
    localparam int QB = OB + 1;                        // quotient bits produced
    localparam int TB = FRAC_BITS + 1;                 // tolerance width
    localparam int EB = COORD_BITS + 1;                // edge vector width
    localparam int MB = 2 * EB;                        // edge product width
    localparam int DB = MB + 2;                        // dot product width
    localparam int PB = 2 * DB;                        // Gram product width
    localparam int NB = PB + 1;                        // den / numerator width
    localparam int XB = NB + TB + FRAC_BITS + 3;       // inside-test compare width
    localparam int RB = NB + FRAC_BITS + QB + 4;       // divider remainder width
    localparam int NS = 8 + QB + 1;                    // pipeline stages with valid bits
    localparam int LB = NB / 2;                        // low slice of den for the tolerance product
    localparam logic [QB-1:0] LIM_POS = QB'((1 << (OB - 1)) - 1);
    localparam logic [QB-1:0] LIM_NEG = QB'(1 << (OB - 1));

    logic          r_vld [NS];
    logic          w_en;
    logic [TB-1:0] r_tol;

    // Advance the whole pipe unless the result register holds an untaken beat.
    assign w_en       = !r_vld[NS-1] || o_res.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_pt.valid;
            for (int s = 1; s < NS; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Stage 1: edge vectors e0 = c - a, e1 = b - a, e2 = p - a.
    logic signed [EB-1:0] r_e0 [3];
    logic signed [EB-1:0] r_e1 [3];
    logic signed [EB-1:0] r_e2 [3];
    logic signed [COORD_BITS-1:0] w_pa [3];
    logic signed [COORD_BITS-1:0] w_pb [3];
    logic signed [COORD_BITS-1:0] w_pc [3];
    logic signed [COORD_BITS-1:0] w_pp [3];

    assign w_pa[0] = i_pt.vert_a_x;
    assign w_pa[1] = i_pt.vert_a_y;
    assign w_pa[2] = i_pt.vert_a_z;
    assign w_pb[0] = i_pt.vert_b_x;
    assign w_pb[1] = i_pt.vert_b_y;
    assign w_pb[2] = i_pt.vert_b_z;
    assign w_pc[0] = i_pt.vert_c_x;
    assign w_pc[1] = i_pt.vert_c_y;
    assign w_pc[2] = i_pt.vert_c_z;
    assign w_pp[0] = i_pt.point_x;
    assign w_pp[1] = i_pt.point_y;
    assign w_pp[2] = i_pt.point_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e0[k] <= EB'(w_pc[k]) - EB'(w_pa[k]);
                r_e1[k] <= EB'(w_pb[k]) - EB'(w_pa[k]);
                r_e2[k] <= EB'(w_pp[k]) - EB'(w_pa[k]);
            end
        end
    end

    // Stage 2: per-axis products for the five dot products.
    logic signed [MB-1:0] r_p00 [3];
    logic signed [MB-1:0] r_p01 [3];
    logic signed [MB-1:0] r_p02 [3];
    logic signed [MB-1:0] r_p11 [3];
    logic signed [MB-1:0] r_p12 [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p00[k] <= r_e0[k] * r_e0[k];
                r_p01[k] <= r_e0[k] * r_e1[k];
                r_p02[k] <= r_e0[k] * r_e2[k];
                r_p11[k] <= r_e1[k] * r_e1[k];
                r_p12[k] <= r_e1[k] * r_e2[k];
            end
        end
    end

    // Stage 3: sum the axes.
    logic signed [DB-1:0] r_d00, r_d01, r_d02, r_d11, r_d12;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d00 <= DB'(r_p00[0]) + DB'(r_p00[1]) + DB'(r_p00[2]);
            r_d01 <= DB'(r_p01[0]) + DB'(r_p01[1]) + DB'(r_p01[2]);
            r_d02 <= DB'(r_p02[0]) + DB'(r_p02[1]) + DB'(r_p02[2]);
            r_d11 <= DB'(r_p11[0]) + DB'(r_p11[1]) + DB'(r_p11[2]);
            r_d12 <= DB'(r_p12[0]) + DB'(r_p12[1]) + DB'(r_p12[2]);
        end
    end

    // Stage 4: Gram and numerator products.
    logic signed [PB-1:0] r_m0011, r_m0101, r_m1102, r_m0112, r_m0012, r_m0102;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0011 <= r_d00 * r_d11;
            r_m0101 <= r_d01 * r_d01;
            r_m1102 <= r_d11 * r_d02;
            r_m0112 <= r_d01 * r_d12;
            r_m0012 <= r_d00 * r_d12;
            r_m0102 <= r_d01 * r_d02;
        end
    end

    // Stage 5: denominator and the two numerators.
    logic signed [NB-1:0] r_den5, r_un5, r_vn5;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den5 <= NB'(r_m0011) - NB'(r_m0101);
            r_un5  <= NB'(r_m1102) - NB'(r_m0112);
            r_vn5  <= NB'(r_m0012) - NB'(r_m0102);
        end
    end

    // Stage 6: tolerance times denominator as two narrow partial products (den is never
    // negative, so both slices are unsigned); flag a degenerate triangle.
    logic [LB+TB-1:0]      r_tdl;
    logic [NB-LB+TB-1:0]   r_tdh;
    logic signed [NB-1:0]  r_den6, r_un6, r_vn6;
    logic                  r_dg6;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdl  <= r_den5[LB-1:0] * r_tol;
            r_tdh  <= r_den5[NB-1:LB] * r_tol;
            r_den6 <= r_den5;
            r_un6  <= r_un5;
            r_vn6  <= r_vn5;
            r_dg6  <= (r_den5 == '0);
        end
    end

    // Stage 7: scaled sides of the inside test and the rounded dividends.
    logic signed [XB-1:0] r_us, r_vs, r_sm, r_lm;
    logic [RB-1:0]        r_n2u, r_n2v, r_dd7;
    logic                 r_sgu7, r_sgv7, r_dg7;
    logic [NB-1:0]        w_magu, w_magv;
    logic [XB-1:0]        w_tden;

    assign w_magu = r_un6[NB-1] ? NB'(-r_un6) : NB'(r_un6);
    assign w_magv = r_vn6[NB-1] ? NB'(-r_vn6) : NB'(r_vn6);
    // merge the partial products into tolerance * den
    assign w_tden = (XB'(r_tdh) << LB) + XB'(r_tdl);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_us   <= (XB'(r_un6) <<< FRAC_BITS) + w_tden;
            r_vs   <= (XB'(r_vn6) <<< FRAC_BITS) + w_tden;
            r_sm   <= (XB'(r_un6) + XB'(r_vn6)) <<< FRAC_BITS;
            r_lm   <= (XB'(r_den6) <<< FRAC_BITS) + w_tden;
            // round to nearest: (mag * 2^(F+1) + den) / (2 * den)
            r_n2u  <= (RB'(w_magu) << (FRAC_BITS + 1)) + RB'($unsigned(r_den6));
            r_n2v  <= (RB'(w_magv) << (FRAC_BITS + 1)) + RB'($unsigned(r_den6));
            r_dd7  <= RB'($unsigned(r_den6)) << 1;
            r_sgu7 <= r_un6[NB-1];
            r_sgv7 <= r_vn6[NB-1];
            r_dg7  <= r_dg6;
        end
    end

    // Stage 8 (divider index 0): inside decision and quotient overflow check.
    logic [RB-1:0] r_ru [QB+1];
    logic [RB-1:0] r_rv [QB+1];
    logic [QB-1:0] r_qu [QB+1];
    logic [QB-1:0] r_qv [QB+1];
    logic [RB-1:0] r_dd [QB+1];
    logic          r_sgu [QB+1];
    logic          r_sgv [QB+1];
    logic          r_ovu [QB+1];
    logic          r_ovv [QB+1];
    logic          r_in [QB+1];
    logic          r_dg [QB+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in[0]  <= !r_dg7 && (r_us >= 0) && (r_vs >= 0) && (r_sm <= r_lm);
            r_ovu[0] <= r_n2u >= (r_dd7 << QB);
            r_ovv[0] <= r_n2v >= (r_dd7 << QB);
            r_ru[0]  <= r_n2u;
            r_rv[0]  <= r_n2v;
            r_qu[0]  <= '0;
            r_qv[0]  <= '0;
            r_dd[0]  <= r_dd7;
            r_sgu[0] <= r_sgu7;
            r_sgv[0] <= r_sgv7;
            r_dg[0]  <= r_dg7;
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first.
    for (genvar g = 0; g < QB; g++) begin : g_div
        localparam int J = QB - 1 - g;
        logic [RB-1:0] w_tu, w_tv;
        logic          w_ge_u, w_ge_v;

        assign w_tu   = r_dd[g] << J;
        assign w_tv   = r_dd[g] << J;
        assign w_ge_u = r_ru[g] >= w_tu;
        assign w_ge_v = r_rv[g] >= w_tv;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ru[g+1]  <= w_ge_u ? r_ru[g] - w_tu : r_ru[g];
                r_rv[g+1]  <= w_ge_v ? r_rv[g] - w_tv : r_rv[g];
                r_qu[g+1]  <= r_qu[g] | (QB'(w_ge_u) << J);
                r_qv[g+1]  <= r_qv[g] | (QB'(w_ge_v) << J);
                r_dd[g+1]  <= r_dd[g];
                r_sgu[g+1] <= r_sgu[g];
                r_sgv[g+1] <= r_sgv[g];
                r_ovu[g+1] <= r_ovu[g];
                r_ovv[g+1] <= r_ovv[g];
                r_in[g+1]  <= r_in[g];
                r_dg[g+1]  <= r_dg[g];
            end
        end
    end

    // Output stage: saturate, restore sign, zero the weights of a degenerate triangle.
    logic [QB-1:0]        w_limu, w_limv, w_qu, w_qv;
    logic signed [OB-1:0] w_bu, w_bv;
    logic                 r_o_in, r_o_dg;
    logic signed [OB-1:0] r_o_bu, r_o_bv;

    assign w_limu = r_sgu[QB] ? LIM_NEG : LIM_POS;
    assign w_limv = r_sgv[QB] ? LIM_NEG : LIM_POS;
    assign w_qu   = (r_ovu[QB] || r_qu[QB] > w_limu) ? w_limu : r_qu[QB];
    assign w_qv   = (r_ovv[QB] || r_qv[QB] > w_limv) ? w_limv : r_qv[QB];
    assign w_bu   = r_sgu[QB] ? OB'(-w_qu) : OB'(w_qu);
    assign w_bv   = r_sgv[QB] ? OB'(-w_qv) : OB'(w_qv);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_in <= r_in[QB];
            r_o_dg <= r_dg[QB];
            r_o_bu <= r_dg[QB] ? '0 : w_bu;
            r_o_bv <= r_dg[QB] ? '0 : w_bv;
        end
    end

    assign o_res.valid      = r_vld[NS-1];
    assign o_res.inside_res = r_o_in;
    assign o_res.degenerate = r_o_dg;
    assign o_res.bary_u     = r_o_bu;
    assign o_res.bary_v     = r_o_bv;
endmodule
